>>> rtl/core/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types, constants and codes for the stack with middle delete.
// ----------------------------------------------------------------------------
package smd_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int T_DEPTH = (DEPTH + 1) / 2;
   localparam int B_DEPTH = DEPTH / 2;
   localparam int IDX_W   = $clog2(T_DEPTH + 1);

   localparam logic [1:0] ACT_PUSH   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef enum logic [2:0] {
      MODE_HOLD,
      MODE_LOAD_AT,
      MODE_SHIFT_LOAD,
      MODE_SHIFT_NEXT,
      MODE_SHIFT_PREV,
      MODE_BASE_PREV
   } chain_mode_type;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] push_value;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] middle_value;
      logic               middle_valid;
      logic [4:0]         entry_count;
      logic [1:0]         status;
   } rsp_item_type;

   typedef struct packed {
      chain_mode_type   t_mode;
      chain_mode_type   b_mode;
      logic [IDX_W-1:0] t_size;
   } chain_ctl_type;

endpackage

>>> rtl/core/smd_cell.sv
// ----------------------------------------------------------------------------
// smd_cell
// One word of a stack chain: holds, shifts from a neighbor or loads the
// pushed word, as its chain mode and its place in the chain decide.
// ----------------------------------------------------------------------------
module smd_cell (
   input  logic                         clock,
   input  smd_pkg::chain_mode_type      mode,
   input  logic [smd_pkg::IDX_W-1:0]    idx,
   input  logic [smd_pkg::IDX_W-1:0]    size,
   input  logic signed [31:0]           prev_data,
   input  logic signed [31:0]           next_data,
   input  logic signed [31:0]           load_data,
   output logic signed [31:0]           data_q,
   output logic signed [31:0]           data_nxt
);

   logic signed [31:0]          data_ff;
   logic signed [31:0]          data_in;
   logic [smd_pkg::IDX_W:0]     idx_plus;
   logic [smd_pkg::IDX_W:0]     size_ext;

   assign idx_plus = {1'b0, idx} + {{smd_pkg::IDX_W{1'b0}}, 1'b1};
   assign size_ext = {1'b0, size};

   always_comb begin
      data_in = data_ff;
      unique case (mode)
         smd_pkg::MODE_HOLD: begin
            data_in = data_ff;
         end
         smd_pkg::MODE_LOAD_AT: begin
            if (idx == size) data_in = load_data;
         end
         smd_pkg::MODE_SHIFT_LOAD: begin
            if (idx_plus == size_ext) begin
               data_in = load_data;
            end else if (idx_plus < size_ext) begin
               data_in = next_data;
            end
         end
         smd_pkg::MODE_SHIFT_NEXT: begin
            data_in = next_data;
         end
         smd_pkg::MODE_SHIFT_PREV: begin
            data_in = prev_data;
         end
         smd_pkg::MODE_BASE_PREV: begin
            if (idx == '0) data_in = prev_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q   = data_ff;
   assign data_nxt = data_in;

endmodule

>>> rtl/core/smd_ctl.sv
// ----------------------------------------------------------------------------
// smd_ctl
// Entry count and chain control: picks the shift mode of the upper chain
// (middle up to top) and the lower chain (below the middle) for each item.
// ----------------------------------------------------------------------------
module smd_ctl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [1:0]                  action,
   output smd_pkg::chain_ctl_type      ctl,
   output logic [smd_pkg::CNT_W-1:0]   count_q,
   output logic [smd_pkg::CNT_W-1:0]   count_nxt,
   output logic [1:0]                  status
);

   logic [smd_pkg::CNT_W-1:0] count_ff;
   logic [smd_pkg::CNT_W-1:0] count_in;
   logic [smd_pkg::CNT_W:0]   half_sum;
   logic                      odd;
   logic                      is_full;
   logic                      is_empty;

   assign odd      = count_ff[0];
   assign is_full  = (count_ff == smd_pkg::CNT_W'(smd_pkg::DEPTH));
   assign is_empty = (count_ff == '0);
   assign half_sum = ({1'b0, count_ff} + {{smd_pkg::CNT_W{1'b0}}, 1'b1}) >> 1;

   always_comb begin
      count_in      = count_ff;
      status        = smd_pkg::STAT_DONE;
      ctl.t_mode    = smd_pkg::MODE_HOLD;
      ctl.b_mode    = smd_pkg::MODE_HOLD;
      ctl.t_size    = half_sum[smd_pkg::IDX_W-1:0];
      unique case (action)
         smd_pkg::ACT_PUSH: begin
            if (is_full) begin
               status = smd_pkg::STAT_FULL;
            end else begin
               count_in = count_ff + smd_pkg::CNT_W'(1);
               if (odd) begin
                  ctl.t_mode = smd_pkg::MODE_SHIFT_LOAD;
                  ctl.b_mode = smd_pkg::MODE_SHIFT_PREV;
               end else begin
                  ctl.t_mode = smd_pkg::MODE_LOAD_AT;
               end
            end
         end
         smd_pkg::ACT_POP: begin
            if (is_empty) begin
               status = smd_pkg::STAT_EMPTY;
            end else begin
               count_in = count_ff - smd_pkg::CNT_W'(1);
               if (!odd) begin
                  ctl.t_mode = smd_pkg::MODE_SHIFT_PREV;
                  ctl.b_mode = smd_pkg::MODE_SHIFT_NEXT;
               end
            end
         end
         smd_pkg::ACT_DELETE: begin
            if (is_empty) begin
               status = smd_pkg::STAT_EMPTY;
            end else begin
               count_in = count_ff - smd_pkg::CNT_W'(1);
               if (odd) begin
                  ctl.t_mode = smd_pkg::MODE_SHIFT_NEXT;
               end else begin
                  ctl.t_mode = smd_pkg::MODE_BASE_PREV;
                  ctl.b_mode = smd_pkg::MODE_SHIFT_NEXT;
               end
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      if (!accept) begin
         count_in   = count_ff;
         ctl.t_mode = smd_pkg::MODE_HOLD;
         ctl.b_mode = smd_pkg::MODE_HOLD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count_q   = count_ff;
   assign count_nxt = count_in;

endmodule

>>> rtl/core/stack_with_middle_delete_top.sv
// ----------------------------------------------------------------------------
// stack_with_middle_delete_top
// Bounded stack of signed words with push, pop and delete-middle, built as
// two cell chains that meet at the middle entry.
// ----------------------------------------------------------------------------
// Latency: the result of an item is valid the cycle after it is accepted.
// Throughput: one item per cycle unless the result stalls; each cell shifts or holds per item.
// A new item is taken once the result register is empty or being drained.
// Reset clears the entry count and the result valid; cell contents are
// left as they are and never read before they are written.
module stack_with_middle_delete_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  smd_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output smd_pkg::rsp_item_type rsp_item
);

   logic                        req_fire;
   smd_pkg::chain_ctl_type      ctl;
   logic [smd_pkg::CNT_W-1:0]   count_q;
   logic [smd_pkg::CNT_W-1:0]   count_nxt;
   logic [1:0]                  status;
   logic [smd_pkg::CNT_W+4:0]   count_wide;

   logic signed [31:0] t_q   [smd_pkg::T_DEPTH];
   logic signed [31:0] t_nxt [smd_pkg::T_DEPTH];
   logic signed [31:0] b_q   [smd_pkg::B_DEPTH];
   logic signed [31:0] b_nxt [smd_pkg::B_DEPTH];

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   smd_pkg::rsp_item_type rsp_item_ff;
   smd_pkg::rsp_item_type rsp_item_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   smd_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_fire),
      .action    (req_item.action),
      .ctl       (ctl),
      .count_q   (count_q),
      .count_nxt (count_nxt),
      .status    (status)
   );

   for (genvar i = 0; i < smd_pkg::T_DEPTH; i++) begin : g_top_chain
      smd_cell u_cell (
         .clock     (clock),
         .mode      (ctl.t_mode),
         .idx       (smd_pkg::IDX_W'(i)),
         .size      (ctl.t_size),
         .prev_data ((i == 0) ? b_q[0] : t_q[(i == 0) ? 0 : i - 1]),
         .next_data ((i == smd_pkg::T_DEPTH - 1) ? 32'sd0
                     : t_q[(i == smd_pkg::T_DEPTH - 1) ? i : i + 1]),
         .load_data (req_item.push_value),
         .data_q    (t_q[i]),
         .data_nxt  (t_nxt[i])
      );
   end

   for (genvar i = 0; i < smd_pkg::B_DEPTH; i++) begin : g_low_chain
      smd_cell u_cell (
         .clock     (clock),
         .mode      (ctl.b_mode),
         .idx       (smd_pkg::IDX_W'(0)),
         .size      (ctl.t_size),
         .prev_data ((i == 0) ? t_q[0] : b_q[(i == 0) ? 0 : i - 1]),
         .next_data ((i == smd_pkg::B_DEPTH - 1) ? 32'sd0
                     : b_q[(i == smd_pkg::B_DEPTH - 1) ? i : i + 1]),
         .load_data (req_item.push_value),
         .data_q    (b_q[i]),
         .data_nxt  (b_nxt[i])
      );
   end

   assign count_wide = (smd_pkg::CNT_W + 5)'(count_nxt);

   always_comb begin
      rsp_item_in.middle_valid = (count_nxt != '0);
      rsp_item_in.middle_value = (count_nxt != '0) ? t_nxt[0] : 32'sd0;
      rsp_item_in.entry_count  = count_wide[4:0];
      rsp_item_in.status       = status;
      rsp_valid_in             = rsp_valid_ff && !rsp_ready;
      if (req_fire) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_item.action == smd_pkg::ACT_PUSH
         && count_q != smd_pkg::CNT_W'(smd_pkg::DEPTH)
      |=> count_q == $past(count_q) + smd_pkg::CNT_W'(1))
      else $error("push did not grow the stack");

   a_mid_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.middle_valid == (rsp_item.entry_count != 5'd0))
      else $error("middle valid disagrees with entry count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_item.status == smd_pkg::STAT_FULL)
         == ($past(req_item.action) == smd_pkg::ACT_PUSH
             && $past(count_q) == smd_pkg::CNT_W'(smd_pkg::DEPTH)))
      else $error("full status mismatch");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      1'b1 |-> count_q <= smd_pkg::CNT_W'(smd_pkg::DEPTH))
      else $error("entry count beyond depth");

endmodule

>>> tb/stack_with_middle_delete_checker.sv
// ----------------------------------------------------------------------------
// stack_with_middle_delete_checker
// Watches both channels of the stack, predicts each result from the accepted
// items and compares every field in order of arrival.
// ----------------------------------------------------------------------------
module stack_with_middle_delete_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  smd_pkg::req_item_type req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  smd_pkg::rsp_item_type rsp_item,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import smd_pkg::*;

   logic signed [31:0] stack_words [DEPTH];
   int                 depth_used;
   rsp_item_type       expected_q [$];

   function automatic int middle_slot();
      return depth_used - 1 - (depth_used - 1) / 2;
   endfunction

   function automatic rsp_item_type apply_action(input req_item_type item);
      rsp_item_type res;
      int           mid;
      res = '0;
      res.status = STAT_DONE;
      case (item.action)
         ACT_PUSH: begin
            if (depth_used >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               stack_words[depth_used] = item.push_value;
               depth_used++;
            end
         end
         ACT_POP: begin
            if (depth_used == 0) res.status = STAT_EMPTY;
            else depth_used--;
         end
         ACT_DELETE: begin
            if (depth_used == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               mid = middle_slot();
               for (int i = mid; i < depth_used - 1; i++) stack_words[i] = stack_words[i + 1];
               depth_used--;
            end
         end
         default: ;
      endcase
      if (depth_used != 0) begin
         res.middle_value = stack_words[middle_slot()];
         res.middle_valid = 1'b1;
      end
      res.entry_count = depth_used[4:0];
      return res;
   endfunction

   task automatic log_failure(input string note);
      fail_count++;
      if (fail_count <= 10) $display("%0t checker: %s", $realtime, note);
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         expected_q.delete();
         depth_used = 0;
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               log_failure($sformatf({"result with none expected: value %0d valid %0b ",
                  "count %0d status %0d"},
                  rsp_item.middle_value, rsp_item.middle_valid, rsp_item.entry_count,
                  rsp_item.status));
            end else begin
               want = expected_q.pop_front();
               if (rsp_item.middle_value !== want.middle_value ||
                   rsp_item.middle_valid !== want.middle_valid ||
                   rsp_item.entry_count !== want.entry_count ||
                   rsp_item.status !== want.status) begin
                  log_failure($sformatf({"mismatch: expected value %0d valid %0b count %0d ",
                     "status %0d, got value %0d valid %0b count %0d status %0d"},
                     want.middle_value, want.middle_valid, want.entry_count, want.status,
                     rsp_item.middle_value, rsp_item.middle_valid, rsp_item.entry_count,
                     rsp_item.status));
               end
            end
         end
         if (req_valid && req_ready) expected_q.push_back(apply_action(req_item));
      end
      pending_count = expected_q.size();
   end

endmodule

>>> tb/stack_with_middle_delete_top_test.sv
// ----------------------------------------------------------------------------
// stack_with_middle_delete_top_test
// Drives push, pop, delete-middle and no-op items into the stack with random gaps
// and result stalls, including a long stall that backs up the input, and
// reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module stack_with_middle_delete_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import smd_pkg::*;

   localparam logic [1:0] ACT_NOP = 2'd3;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;
   int           fail_count;
   int           pending_count;
   bit           calm      = 1'b0;

   stack_with_middle_delete_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   stack_with_middle_delete_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_item(input logic [1:0] act, input logic signed [31:0] val);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{action: act, push_value: val};
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [1:0] pick_action(input int push_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return ACT_NOP;
      if (roll < 3 + push_pct) return ACT_PUSH;
      return ($urandom_range(0, 1) == 0) ? ACT_POP : ACT_DELETE;
   endfunction

   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   initial begin : make_items
      int push_pct;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_item(ACT_POP, 32'sd0);
      send_item(ACT_DELETE, 32'sd0);
      send_item(ACT_NOP, -32'sd1);
      send_item(ACT_PUSH, 32'sh8000_0000);
      send_item(ACT_PUSH, 32'sh7FFF_FFFF);
      send_item(ACT_PUSH, 32'sd0);
      send_item(ACT_PUSH, -32'sd1);
      send_item(ACT_PUSH, 32'sh5555_5555);
      send_item(ACT_PUSH, 32'shAAAA_AAAA);
      repeat (10) send_item(ACT_PUSH, $urandom);
      send_item(ACT_PUSH, 32'sh1234_5678);
      send_item(ACT_NOP, 32'sd0);
      send_item(ACT_DELETE, 32'sd0);
      send_item(ACT_DELETE, 32'sd0);
      send_item(ACT_POP, 32'sd0);

      for (int phase = 0; phase < 14; phase++) begin
         calm = ($urandom_range(0, 3) == 0);
         case (phase % 3)
            0: push_pct = 75;
            1: push_pct = 25;
            default: push_pct = 50;
         endcase
         repeat (50) send_item(pick_action(push_pct), random_word());
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : drain_results
      int stall;
      int taken;
      taken = 0;
      repeat (6) @(posedge clock);
      forever begin
         if (taken % 200 == 100) stall = 60;
         else stall = calm ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin : watchdog
      #1_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/smd_pkg.sv
rtl/core/smd_cell.sv
rtl/core/smd_ctl.sv
rtl/core/stack_with_middle_delete_top.sv
tb/stack_with_middle_delete_checker.sv
tb/stack_with_middle_delete_top_test.sv
